// ===== rtl/core/hrhc_pkg.sv =====
`timescale 1ns / 1ps

package hrhc_pkg;

  // Parse phases of the request head
  typedef enum logic [3:0] {
    PH_W0S   = 4'd0,
    PH_W0    = 4'd1,
    PH_W1S   = 4'd2,
    PH_W1    = 4'd3,
    PH_W2S   = 4'd4,
    PH_W2    = 4'd5,
    PH_EOL   = 4'd6,
    PH_HLINE = 4'd7,
    PH_HNAME = 4'd8,
    PH_HVAL  = 4'd9,
    PH_DONE  = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    VC_OK    = 2'd0,
    VC_BAD   = 2'd1,
    VC_NIMPL = 2'd2
  } verdict_t;

  localparam logic KIND_PATH    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  localparam logic [2:0] GET_LEN  = 3'd3;
  localparam logic [2:0] HEAD_LEN = 3'd4;
  localparam logic [2:0] VER_LEN  = 3'd6;
  localparam logic [2:0] POS_MAX  = 3'd7;

  typedef struct packed {
    phase_t      phase;
    logic        cr_pending;
    logic [2:0]  method_pos;
    logic        is_get;
    logic        is_head;
    logic [2:0]  ver_pos;
    logic        ver_bad;
    logic        path_started;
    logic        slash_first;
    logic [1:0]  esc_phase;
    logic [3:0]  esc_hi;
    logic        dec_bad;
    logic        header_seen;
  } hrhc_state_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [7:0]  path_byte;
    verdict_t    code;
    logic        is_head;
  } hrhc_result_t;

  typedef struct packed {
    hrhc_state_t  st;
    hrhc_result_t res;
  } hrhc_feed_t;

  localparam hrhc_state_t STATE_RESET = '{
    phase:        PH_W0S,
    cr_pending:   1'b0,
    method_pos:   3'd0,
    is_get:       1'b1,
    is_head:      1'b1,
    ver_pos:      3'd0,
    ver_bad:      1'b0,
    path_started: 1'b0,
    slash_first:  1'b0,
    esc_phase:    2'd0,
    esc_hi:       4'd0,
    dec_bad:      1'b0,
    header_seen:  1'b0
  };

endpackage

// ===== rtl/core/hrhc_step.sv =====
`timescale 1ns / 1ps

module hrhc_step (
  input  hrhc_pkg::hrhc_state_t  state_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   stream_end_i,
  output hrhc_pkg::hrhc_state_t  state_o,
  output hrhc_pkg::hrhc_result_t res_o
);
  import hrhc_pkg::*;

  function automatic logic [7:0] get_char(input logic [2:0] p);
    case (p)
      3'd0:    get_char = "G";
      3'd1:    get_char = "E";
      3'd2:    get_char = "T";
      default: get_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] head_char(input logic [2:0] p);
    case (p)
      3'd0:    head_char = "H";
      3'd1:    head_char = "E";
      3'd2:    head_char = "A";
      3'd3:    head_char = "D";
      default: head_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] p);
    case (p)
      3'd0:    ver_char = "H";
      3'd1:    ver_char = "T";
      3'd2:    ver_char = "T";
      3'd3:    ver_char = "P";
      3'd4:    ver_char = "/";
      3'd5:    ver_char = "1";
      default: ver_char = 8'h00;
    endcase
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= "0" && c <= "9") h = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") h = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") h = {1'b1, 4'(c - "A" + 8'd10)};
    hex_val = h;
  endfunction

  function automatic hrhc_result_t mk_verdict(input hrhc_state_t s, input verdict_t code);
    hrhc_result_t r;
    r.valid     = 1'b1;
    r.kind      = KIND_VERDICT;
    r.path_byte = 8'h00;
    r.code      = code;
    r.is_head   = s.is_head && (s.method_pos == HEAD_LEN);
    mk_verdict  = r;
  endfunction

  function automatic hrhc_result_t mk_path(input logic [7:0] b);
    hrhc_result_t r;
    r.valid     = 1'b1;
    r.kind      = KIND_PATH;
    r.path_byte = b;
    r.code      = VC_OK;
    r.is_head   = 1'b0;
    mk_path     = r;
  endfunction

  // One character through the parser; word boundaries fall straight through
  // to the end-of-line check without looping.
  function automatic hrhc_feed_t feed(input hrhc_state_t s, input logic [7:0] c);
    hrhc_state_t  n;
    hrhc_result_t r;
    hrhc_feed_t   f;
    logic         blank;
    logic         space;
    logic         eol;
    logic         word;
    logic [4:0]   hv;
    n     = s;
    r     = '0;
    blank = (c == CH_SP) || (c == CH_TAB);
    space = blank || (c == CH_LF) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    eol   = 1'b0;
    word  = 1'b0;
    hv    = hex_val(c);

    case (s.phase)
      PH_W0S, PH_W1S, PH_W2S: begin
        if (!blank) begin
          if (space) begin
            eol = 1'b1;
          end else begin
            word = 1'b1;
            case (s.phase)
              PH_W0S:  n.phase = PH_W0;
              PH_W1S:  n.phase = PH_W1;
              default: n.phase = PH_W2;
            endcase
          end
        end
      end
      PH_W0, PH_W1, PH_W2: begin
        if (space) begin
          // unfinished escape at the end of the path
          if (s.phase == PH_W1 && s.esc_phase != 2'd0) begin
            n.dec_bad   = 1'b1;
            n.esc_phase = 2'd0;
          end
          if (blank && s.phase != PH_W2) begin
            n.phase = (s.phase == PH_W0) ? PH_W1S : PH_W2S;
          end else begin
            eol = 1'b1;
          end
        end else begin
          word = 1'b1;
        end
      end
      PH_EOL: eol = 1'b1;
      PH_HLINE: begin
        if (c == CH_LF) begin
          n.phase = PH_DONE;
          r = mk_verdict(n, VC_OK);
        end else if (blank) begin
          if (s.header_seen) begin
            n.phase = PH_HVAL;
          end else begin
            n.phase = PH_DONE;
            r = mk_verdict(n, VC_BAD);
          end
        end else if (c == CH_COLON) begin
          n.phase = PH_DONE;
          r = mk_verdict(n, VC_BAD);
        end else begin
          n.phase = PH_HNAME;
        end
      end
      PH_HNAME: begin
        if (c == CH_COLON) begin
          n.header_seen = 1'b1;
          n.phase       = PH_HVAL;
        end else if (c == CH_LF) begin
          n.phase = PH_DONE;
          r = mk_verdict(n, VC_BAD);
        end
      end
      PH_HVAL: begin
        if (c == CH_LF) n.phase = PH_HLINE;
      end
      default: ;
    endcase

    if (word) begin
      case (n.phase)
        PH_W0: begin
          if (!(n.method_pos < GET_LEN && c == get_char(n.method_pos))) n.is_get = 1'b0;
          if (!(n.method_pos < HEAD_LEN && c == head_char(n.method_pos))) n.is_head = 1'b0;
          if (n.method_pos < POS_MAX) n.method_pos = 3'(n.method_pos + 3'd1);
        end
        PH_W1: begin
          if (!n.path_started) begin
            n.path_started = 1'b1;
            n.slash_first  = (c == CH_SLASH);
          end
          if (!n.dec_bad) begin
            if (n.esc_phase == 2'd0) begin
              if (c == CH_PLUS) r = mk_path(CH_SP);
              else if (c == CH_PCT) n.esc_phase = 2'd1;
              else if (c == CH_AMP || c == CH_EQ) n.dec_bad = 1'b1;
              else r = mk_path(c);
            end else if (!hv[4]) begin
              n.dec_bad   = 1'b1;
              n.esc_phase = 2'd0;
            end else if (n.esc_phase == 2'd1) begin
              n.esc_hi    = hv[3:0];
              n.esc_phase = 2'd2;
            end else begin
              n.esc_phase = 2'd0;
              r = mk_path({n.esc_hi, hv[3:0]});
            end
          end
        end
        PH_W2: begin
          if (n.ver_pos < VER_LEN) begin
            if (c != ver_char(n.ver_pos)) n.ver_bad = 1'b1;
            n.ver_pos = 3'(n.ver_pos + 3'd1);
          end
        end
        default: ;
      endcase
    end

    if (eol) begin
      n.phase = PH_DONE;
      if (c != CH_LF) begin
        r = mk_verdict(n, VC_BAD);
      end else if (!((n.is_get && n.method_pos == GET_LEN) ||
                     (n.is_head && n.method_pos == HEAD_LEN))) begin
        r = mk_verdict(n, VC_NIMPL);
      end else if (n.ver_bad || n.ver_pos < VER_LEN) begin
        r = mk_verdict(n, VC_NIMPL);
      end else if (!n.slash_first) begin
        r = mk_verdict(n, VC_NIMPL);
      end else if (n.dec_bad) begin
        r = mk_verdict(n, VC_BAD);
      end else begin
        n.phase = PH_HLINE;
      end
    end

    f.st  = n;
    f.res = r;
    feed  = f;
  endfunction

  always_comb begin
    hrhc_state_t  t;
    hrhc_result_t r;
    hrhc_feed_t   f;
    logic         use_byte;
    t        = state_i;
    r        = '0;
    f        = '0;
    use_byte = 1'b1;
    if (stream_end_i) begin
      if (state_i.phase != PH_DONE) r = mk_verdict(state_i, VC_BAD);
      t = STATE_RESET;
    end else if (state_i.phase != PH_DONE) begin
      // resolve a held CR: folded into LF, or fed as a lone CR
      if (t.cr_pending) begin
        t.cr_pending = 1'b0;
        if (rx_byte_i == CH_LF) begin
          f        = feed(t, CH_LF);
          use_byte = 1'b0;
        end else begin
          f = feed(t, CH_CR);
        end
        t = f.st;
        r = f.res;
      end
      if (use_byte && t.phase != PH_DONE) begin
        if (rx_byte_i == CH_CR) begin
          t.cr_pending = 1'b1;
        end else begin
          f = feed(t, rx_byte_i);
          t = f.st;
          if (f.res.valid) r = f.res;
        end
      end
    end
    state_o = t;
    res_o   = r;
  end

endmodule

// ===== rtl/core/http_request_head_checker.sv =====
`timescale 1ns / 1ps

// HTTP/1 request head checker. Takes one request byte per cycle on the in_
// stream while the output is not stalled and returns decoded path bytes as
// they complete, then a single verdict (ok, bad request, not implemented)
// with a HEAD flag. A byte is held in the input register, the parser step
// between the input and output registers is combinational, and its result
// is registered in the output register. Input is taken whenever the input
// register is empty or drains, so a waiting result stops the next byte only
// once the input register is full. Bytes after the verdict are swallowed
// until in_tlast marks the end of the connection; an end before any verdict
// yields a bad request verdict, and the parser then starts afresh.
module http_request_head_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // stream_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] path_byte, [9:8] verdict_code, [10] is_head
  output logic        out_tuser   // item_kind
);
  import hrhc_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  hrhc_state_t  state_r;
  hrhc_state_t  state_nxt;
  hrhc_result_t step_res;
  logic         out_valid_r;
  logic [15:0]  out_data_r;
  logic         out_kind_r;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  hrhc_step u_step (
    .state_i      (state_r),
    .rx_byte_i    (in_byte_r),
    .stream_end_i (in_last_r),
    .state_o      (state_nxt),
    .res_o        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        state_r     <= state_nxt;
        out_valid_r <= step_res.valid;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (advance && step_res.valid) begin
      out_data_r <= {5'd0, step_res.is_head, step_res.code, step_res.path_byte};
      out_kind_r <= step_res.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

`ifndef ASSERT_OFF
  a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step_res.valid && !in_last_r) |-> (state_r.phase != PH_DONE))
    else $error("result produced after the verdict");

  a_verdict_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_res.valid && step_res.kind == KIND_VERDICT && !in_last_r)
      |=> (state_r.phase == PH_DONE))
    else $error("parser still running after a verdict");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("parser state moved without a request");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_last_r) |=> (state_r == STATE_RESET))
    else $error("parser not reset after stream end");
`endif

endmodule

// ===== tb/http_request_head_checker_chk.sv =====
`timescale 1ns / 1ps

module http_request_head_checker_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // stream_end
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] path_byte, [9:8] verdict_code, [10] is_head
  input  logic        out_tuser,  // item_kind
  output int          mismatches,
  output int          outstanding
);
  import hrhc_pkg::*;

  localparam logic [23:0] GET_WORD     = "GET";
  localparam logic [31:0] HEAD_WORD    = "HEAD";
  localparam logic [47:0] VERSION_WORD = "HTTP/1";

  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    verdict_t   code;
    logic       head;
  } head_result_t;

  head_result_t head_results_due[$];
  hrhc_state_t  st;
  int           mismatch_count = 0;
  int           due_count = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = due_count;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return is_blank(c) || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic logic head_flag();
    return st.is_head && st.method_pos == HEAD_LEN;
  endfunction

  task automatic clear_parser();
    st.phase        = PH_W0S;
    st.cr_pending   = 1'b0;
    st.method_pos   = 3'd0;
    st.is_get       = 1'b1;
    st.is_head      = 1'b1;
    st.ver_pos      = 3'd0;
    st.ver_bad      = 1'b0;
    st.path_started = 1'b0;
    st.slash_first  = 1'b0;
    st.esc_phase    = 2'd0;
    st.esc_hi       = 4'd0;
    st.dec_bad      = 1'b0;
    st.header_seen  = 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic emit_verdict(verdict_t code);
    head_result_t r;
    r = '{kind: KIND_VERDICT, pbyte: 8'h00, code: code, head: head_flag()};
    st.phase = PH_DONE;
    head_results_due.push_back(r);
  endtask

  task automatic emit_path(logic [7:0] b);
    head_result_t r;
    r = '{kind: KIND_PATH, pbyte: b, code: VC_OK, head: 1'b0};
    head_results_due.push_back(r);
  endtask

  task automatic path_char(logic [7:0] c);
    int h;
    if (!st.path_started) begin
      st.path_started = 1'b1;
      st.slash_first  = (c == CH_SLASH);
    end
    if (st.dec_bad) return;
    if (st.esc_phase == 2'd0) begin
      if (c == CH_PLUS) emit_path(CH_SP);
      else if (c == CH_PCT) st.esc_phase = 2'd1;
      else if (c == CH_AMP || c == CH_EQ) st.dec_bad = 1'b1;
      else emit_path(c);
    end else begin
      h = hex_value(c);
      if (h < 0) begin
        st.dec_bad   = 1'b1;
        st.esc_phase = 2'd0;
      end else if (st.esc_phase == 2'd1) begin
        st.esc_hi    = h[3:0];
        st.esc_phase = 2'd2;
      end else begin
        st.esc_phase = 2'd0;
        emit_path({st.esc_hi, h[3:0]});
      end
    end
  endtask

  // A character may close several words in turn, so rerun until it settles.
  task automatic parse_char(logic [7:0] c);
    bit         again;
    logic [2:0] p;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (st.phase)
        PH_W0S, PH_W1S, PH_W2S:
          if (!is_blank(c)) begin
            st.phase = phase_t'(st.phase + (is_space(c) ? 4'd2 : 4'd1));
            again    = 1'b1;
          end
        PH_W0:
          if (is_space(c)) begin
            st.phase = PH_W1S;
            again    = 1'b1;
          end else begin
            p = st.method_pos;
            if (!(p < GET_LEN && c == GET_WORD[8*(2-int'(p)) +: 8])) st.is_get = 1'b0;
            if (!(p < HEAD_LEN && c == HEAD_WORD[8*(3-int'(p)) +: 8])) st.is_head = 1'b0;
            if (p < POS_MAX) st.method_pos = p + 3'd1;
          end
        PH_W1:
          if (is_space(c)) begin
            // an escape cut short by the end of the path is a decode error
            if (st.esc_phase != 2'd0) begin
              st.dec_bad   = 1'b1;
              st.esc_phase = 2'd0;
            end
            st.phase = PH_W2S;
            again    = 1'b1;
          end else begin
            path_char(c);
          end
        PH_W2:
          if (is_space(c)) begin
            st.phase = PH_EOL;
            again    = 1'b1;
          end else if (st.ver_pos < VER_LEN) begin
            if (c != VERSION_WORD[8*(5-int'(st.ver_pos)) +: 8]) st.ver_bad = 1'b1;
            st.ver_pos = st.ver_pos + 3'd1;
          end
        PH_EOL:
          if (c != CH_LF) emit_verdict(VC_BAD);
          else if (!((st.is_get && st.method_pos == GET_LEN) || head_flag()))
            emit_verdict(VC_NIMPL);
          else if (st.ver_bad || st.ver_pos < VER_LEN) emit_verdict(VC_NIMPL);
          else if (!st.slash_first) emit_verdict(VC_NIMPL);
          else if (st.dec_bad) emit_verdict(VC_BAD);
          else st.phase = PH_HLINE;
        PH_HLINE:
          if (c == CH_LF) begin
            emit_verdict(VC_OK);
          end else if (is_blank(c)) begin
            if (st.header_seen) st.phase = PH_HVAL;
            else emit_verdict(VC_BAD);
          end else if (c == CH_COLON) begin
            emit_verdict(VC_BAD);
          end else begin
            st.phase = PH_HNAME;
          end
        PH_HNAME:
          if (c == CH_COLON) begin
            st.header_seen = 1'b1;
            st.phase       = PH_HVAL;
          end else if (c == CH_LF) begin
            emit_verdict(VC_BAD);
          end
        PH_HVAL:
          if (c == CH_LF) st.phase = PH_HLINE;
        default: ;
      endcase
    end
  endtask

  task automatic parse_request_byte(logic [7:0] b, logic last);
    bit take;
    take = 1'b1;
    if (last) begin
      if (st.phase != PH_DONE) emit_verdict(VC_BAD);
      clear_parser();
    end else if (st.phase != PH_DONE) begin
      // hold a CR until the next byte shows whether it folds into LF
      if (st.cr_pending) begin
        st.cr_pending = 1'b0;
        if (b == CH_LF) begin
          parse_char(CH_LF);
          take = 1'b0;
        end else begin
          parse_char(CH_CR);
        end
      end
      if (take && st.phase != PH_DONE) begin
        if (b == CH_CR) st.cr_pending = 1'b1;
        else parse_char(b);
      end
    end
  endtask

  task automatic check_result();
    head_result_t want;
    if (head_results_due.size() == 0) begin
      report_mismatch($sformatf("result with none due: kind %0d data %h", out_tuser, out_tdata));
      return;
    end
    want = head_results_due.pop_front();
    if (out_tuser !== want.kind)
      report_mismatch($sformatf("item_kind %b, want %b", out_tuser, want.kind));
    if (out_tdata[7:0] !== want.pbyte)
      report_mismatch($sformatf("path_byte %h, want %h", out_tdata[7:0], want.pbyte));
    if (out_tdata[9:8] !== 2'(want.code))
      report_mismatch($sformatf("verdict_code %0d, want %0d", out_tdata[9:8], want.code));
    if (out_tdata[10] !== want.head)
      report_mismatch($sformatf("is_head %b, want %b", out_tdata[10], want.head));
    if (out_tdata[15:11] !== 5'd0)
      report_mismatch($sformatf("tdata padding %b, want zero", out_tdata[15:11]));
  endtask

  // Results at an edge come from earlier requests, so check before predicting.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      head_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) parse_request_byte(in_tdata, in_tlast);
    end
    due_count = head_results_due.size();
  end

endmodule

// ===== tb/http_request_head_checker_tb.sv =====
`timescale 1ns / 1ps

module http_request_head_checker_tb;
  import hrhc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_BYTES = 170;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  int          mismatches;
  int          outstanding;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          stall_cycles = 0;
  int          bytes_sent = 0;
  logic [7:0]  req_bytes[$];

  http_request_head_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  http_request_head_checker_chk u_head_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("** http_request_head_checker: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic bit gap_char(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(3))
      0: return 8'("A" + $urandom_range(25));
      1: return 8'("a" + $urandom_range(25));
      2: return 8'("0" + $urandom_range(9));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    if ($urandom_range(1)) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] path_raw();
    logic [7:0] b;
    do b = 8'($urandom);
    while (gap_char(b) || b == CH_PCT || b == CH_PLUS || b == CH_AMP || b == CH_EQ);
    return b;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_LF);
    return b;
  endfunction

  task automatic put(logic [7:0] b);
    req_bytes.push_back(b);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task automatic add_eol();
    if ($urandom_range(1)) put(CH_CR);
    put(CH_LF);
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(3) == 0 ? $urandom_range(2, 3) : 1)
      put($urandom_range(1) ? CH_SP : CH_TAB);
  endtask

  task automatic add_sep();
    if ($urandom_range(29) != 0) begin
      add_blanks();
    end else begin
      case ($urandom_range(3))
        0: put(CH_VT);
        1: put(CH_FF);
        2: put(CH_LF);
        default: put(CH_CR);
      endcase
    end
  endtask

  task automatic path_piece();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: put(word_char());
      4: put(CH_PLUS);
      5, 6: begin
        put(CH_PCT);
        put(hex_char(v[7:4]));
        put(hex_char(v[3:0]));
      end
      7: put(path_raw());
      8: put(CH_SLASH);
      default: add_text("%00");
    endcase
  endtask

  task automatic path_fault();
    case ($urandom_range(4))
      0: begin
        put(CH_PCT);
        put(8'("g" + $urandom_range(19)));
      end
      1: begin
        put(CH_PCT);
        put(hex_char(4'($urandom)));
        put(8'("G" + $urandom_range(19)));
      end
      2: put(CH_AMP);
      3: put(CH_EQ);
      default: put(CH_PCT);
    endcase
  endtask

  task automatic build_request();
    int n;
    int fault_at;
    // drop in plain noise now and then
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 24)) put(8'($urandom));
      return;
    end
    if ($urandom_range(7) == 0) add_blanks();
    case ($urandom_range(11))
      0, 1, 2, 3: add_text("GET");
      4, 5, 6: add_text("HEAD");
      7: repeat ($urandom_range(8)) put(word_char());
      8: add_text("GETS");
      9: add_text("HEA");
      10: add_text("get");
      default: add_text("HEADER");
    endcase
    add_sep();
    if ($urandom_range(11) != 0) put(CH_SLASH);
    n = $urandom_range(8);
    fault_at = ($urandom_range(6) == 0) ? $urandom_range(n) : -1;
    for (int i = 0; i <= n; i++) begin
      if (i == fault_at) path_fault();
      if (i < n) path_piece();
    end
    add_sep();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: add_text("HTTP/1.1");
      6: add_text("HTTP/1.0");
      7: add_text("HTTP/1");
      8: add_text("HTTP/2");
      default: repeat ($urandom_range(7)) put(word_char());
    endcase
    case ($urandom_range(19))
      0: begin
        put(CH_SP);
        add_eol();
      end
      1: begin
        put(CH_CR);
        put(word_char());
      end
      default: add_eol();
    endcase
    repeat ($urandom_range(3)) begin
      if ($urandom_range(24) == 0) begin
        case ($urandom_range(2))
          0: put(CH_COLON);
          1: put($urandom_range(1) ? CH_SP : CH_TAB);
          default: ;
        endcase
        repeat ($urandom_range(1, 4)) put(word_char());
        add_eol();
      end else begin
        repeat ($urandom_range(1, 8)) put(word_char());
        put(CH_COLON);
        if ($urandom_range(1)) put(CH_SP);
        repeat ($urandom_range(6)) put(value_char());
        add_eol();
        if ($urandom_range(4) == 0) begin
          add_blanks();
          repeat ($urandom_range(1, 4)) put(value_char());
          add_eol();
        end
      end
    end
    if ($urandom_range(9) != 0) add_eol();
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 6)) put(8'($urandom));
  endtask

  // Called at a falling edge; returns at the falling edge after the request.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    foreach (req_bytes[i]) send_byte(req_bytes[i], 1'b0);
    send_byte(8'($urandom), 1'b1);
    req_bytes.delete();
  endtask

  task automatic directed(string s);
    add_text(s);
    send_request();
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    directed("GET / HTTP/1.1\015\n\015\n");
    directed("HEAD /a+b%41%4a%Ff HTTP/1.0\nHost: x\n\n");
    directed("GET /x HTTP/1.1\nA: b\n\tfold\n \n\n");
    directed("POST / HTTP/1.1\n\n");
    directed("HEA / HTTP/1.1\n\n");
    directed("GETGETGETGET / HTTP/1.1\n\n");
    directed("GET / HTTP/2\n\n");
    directed("GET / HTTP/\n\n");
    directed("GET abc HTTP/1.1\n\n");
    directed("GET /%zz HTTP/1.1\n\n");
    directed("GET /a&b=c HTTP/1.1\n\n");
    directed("HEAD /%4 HTTP/1.1\n\n");
    directed("GET /%00%ff HTTP/1.1\n\n");
    add_text("GET /");
    put(8'hFF);
    put(8'h80);
    directed(" HTTP/1.1\n\n");
    directed("GET / HTTP/1.1 \n\n");
    directed("GET / HTTP/1.1\015x\n");
    directed("GET\n");
    directed("GET\013/ HTTP/1.1\n\n");
    directed("GET / HTTP/1.1\n x: y\n\n");
    directed("GET / HTTP/1.1\n:x\n\n");
    directed("GET / HTTP/1.1\nName\n\n");
    directed("GET / HT");
    directed("GET / HTTP/1.1\015");
    directed("");
    directed("GET / HTTP/1.1\n\nGET /x HTTP/1.1\n\n");
    directed(" \t GET \t /  HTTP/1.1\nA:\015\015\n\n");
  endtask

  initial begin
    int phase_start;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    run_directed();
    // hold off until every result of the directed part is back
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle = 0;
          recv_idle = 0;
        end
        1: begin
          send_idle = 46;
          recv_idle = 0;
        end
        2: begin
          send_idle = 0;
          recv_idle = 46;
        end
        default: begin
          send_idle = 28;
          recv_idle = 28;
        end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_request();
        send_request();
      end
      drain();
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** http_request_head_checker: PASSED **");
    end else begin
      $display("** http_request_head_checker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hrhc_pkg.sv
rtl/core/hrhc_step.sv
rtl/core/http_request_head_checker.sv
tb/http_request_head_checker_chk.sv
tb/http_request_head_checker_tb.sv
